// ----- rtl/lz77wmt_pkg.sv -----
// Shared types and constants for the LZ77 window match tokenizer.
// Used by the controller, the datapath and the top level; no dependencies.
package lz77wmt_pkg;

    // Shortest match, longest match and window register layout.
    localparam int          MIN_MATCH    = 3;
    localparam logic [7:0]  MAX_LEN      = 8'd255;
    localparam int          CFG_W        = 5;
    localparam logic [4:0]  WINDOW_RESET = 5'd10;

    typedef enum logic
    {
        TK_LITERAL = 1'b0,
        TK_MATCH   = 1'b1
    } token_kind_t;

    typedef struct packed
    {
        token_kind_t kind;
        logic [7:0]  value;
        logic [7:0]  length;
    } token_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic latch;
        logic emit_lit_b;
        logic rd_match;
        logic ext_match;
        logic emit_match;
        logic add_la;
        logic srch_init;
        logic srch_read;
        logic srch_next_k;
        logic srch_next_d;
        logic found;
        logic push_la;
        logic emit_nomatch;
        logic k_clear;
        logic emit_tail;
        logic clear_stream;
        logic flush;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic lit_start;
        logic in_match;
        logic last;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
        logic match_eq;
        logic len_cap;
        logic add_fills;
        logic d_zero;
        logic k_hist;
        logic la_eq;
        logic rd_eq;
        logic k_last;
        logic tail_more;
    } dp_status_t;

endpackage

// ----- rtl/lz77wmt_ctrl.sv -----
// Sequencing state machine of the LZ77 window match tokenizer.
// Depends on lz77wmt_pkg for the command and status structs.
module lz77wmt_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  lz77wmt_pkg::dp_status_t st,
    output lz77wmt_pkg::dp_cmd_t    cmd
);

    typedef enum logic [14:0]
    {
        S_IDLE     = 15'b000000000000001,
        S_DISPATCH = 15'b000000000000010,
        S_MCMP     = 15'b000000000000100,
        S_EMATCH   = 15'b000000000001000,
        S_ADD      = 15'b000000000010000,
        S_SINIT    = 15'b000000000100000,
        S_SRD      = 15'b000000001000000,
        S_SCMP     = 15'b000000010000000,
        S_FOUND    = 15'b000000100000000,
        S_PUSHLA   = 15'b000001000000000,
        S_NOMATCH  = 15'b000010000000000,
        S_ENDCHK   = 15'b000100000000000,
        S_LASTLIT  = 15'b001000000000000,
        S_CLEAR    = 15'b010000000000000,
        S_FLUSH    = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;

    // State and return-point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.lit_start)
                begin
                    if (st.emit_ok)
                    begin
                        cmd.emit_lit_b = 1'b1;
                        state_next     = S_ENDCHK;
                    end
                end
                else if (st.in_match)
                begin
                    cmd.rd_match = 1'b1;
                    state_next   = S_MCMP;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_MCMP:
            begin
                if (st.match_eq)
                begin
                    cmd.ext_match = 1'b1;
                    if (st.len_cap)
                    begin
                        state_next = S_EMATCH;
                        ret_next   = S_ENDCHK;
                    end
                    else
                    begin
                        state_next = S_ENDCHK;
                    end
                end
                else
                begin
                    state_next = S_EMATCH;
                    ret_next   = S_ADD;
                end
            end
            S_EMATCH:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit_match = 1'b1;
                    state_next     = ret_reg;
                end
            end
            S_ADD:
            begin
                cmd.add_la = 1'b1;
                state_next = st.add_fills ? S_SINIT : S_ENDCHK;
            end
            S_SINIT:
            begin
                cmd.srch_init = 1'b1;
                state_next    = S_SRD;
            end
            S_SRD:
            begin
                if (st.d_zero)
                begin
                    state_next = S_NOMATCH;
                end
                else if (st.k_hist)
                begin
                    cmd.srch_read = 1'b1;
                    state_next    = S_SCMP;
                end
                else if (st.la_eq)
                begin
                    if (st.k_last)
                    begin
                        state_next = S_FOUND;
                    end
                    else
                    begin
                        cmd.srch_next_k = 1'b1;
                    end
                end
                else
                begin
                    cmd.srch_next_d = 1'b1;
                end
            end
            S_SCMP:
            begin
                if (st.rd_eq)
                begin
                    if (st.k_last)
                    begin
                        state_next = S_FOUND;
                    end
                    else
                    begin
                        cmd.srch_next_k = 1'b1;
                        state_next      = S_SRD;
                    end
                end
                else
                begin
                    cmd.srch_next_d = 1'b1;
                    state_next      = S_SRD;
                end
            end
            S_FOUND:
            begin
                cmd.found  = 1'b1;
                state_next = S_PUSHLA;
            end
            S_PUSHLA:
            begin
                cmd.push_la = 1'b1;
                if (st.k_last)
                begin
                    state_next = S_ENDCHK;
                end
            end
            S_NOMATCH:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit_nomatch = 1'b1;
                    state_next       = S_ENDCHK;
                end
            end
            S_ENDCHK:
            begin
                cmd.k_clear = 1'b1;
                if (!st.last)
                begin
                    state_next = S_FLUSH;
                end
                else if (st.in_match)
                begin
                    state_next = S_EMATCH;
                    ret_next   = S_LASTLIT;
                end
                else
                begin
                    state_next = S_LASTLIT;
                end
            end
            S_LASTLIT:
            begin
                if (st.tail_more)
                begin
                    if (st.emit_ok)
                    begin
                        cmd.emit_tail = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_stream = 1'b1;
                state_next       = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lz77wmt_dpath.sv -----
// Datapath of the LZ77 window match tokenizer: history memory, lookahead,
// match registers, search counters, token staging and output register.
// Depends on lz77wmt_pkg; driven by lz77wmt_ctrl through dp_cmd_t.
module lz77wmt_dpath
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    input  logic                            cfg_valid,
    input  logic [lz77wmt_pkg::CFG_W-1:0]   cfg_data,
    input  lz77wmt_pkg::dp_cmd_t            cmd,
    output lz77wmt_pkg::dp_status_t         st,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DW = $clog2(MAX_WINDOW + 1);
    localparam int SW = $clog2(2 * MAX_WINDOW);
    localparam int CW = (DW > lz77wmt_pkg::CFG_W) ? DW : lz77wmt_pkg::CFG_W;

    // Pick one of the three lookahead bytes.
    function automatic logic [7:0] la_sel(input logic [7:0] a0, input logic [7:0] a1,
                                          input logic [7:0] a2, input logic [1:0] i);
        logic [7:0] r;
        begin
            case (i)
                2'd0:    r = a0;
                2'd1:    r = a1;
                default: r = a2;
            endcase
            return r;
        end
    endfunction

    // Control registers.
    logic [lz77wmt_pkg::CFG_W-1:0] ws_reg, ws_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic [DW-1:0]                 seen_reg, seen_next;
    logic                          in_match_reg, in_match_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [7:0]                    b_reg, b_next;
    logic                          last_reg, last_next;
    logic [7:0]                    la0_reg, la0_next;
    logic [7:0]                    la1_reg, la1_next;
    logic [7:0]                    la2_reg, la2_next;
    logic [DW-1:0]                 off_reg, off_next;
    logic [7:0]                    len_reg, len_next;
    logic [DW-1:0]                 d_reg, d_next;
    logic [1:0]                    k_reg, k_next;
    lz77wmt_pkg::token_t           pend_reg, pend_next;
    lz77wmt_pkg::token_t           out_tok_reg, out_tok_next;
    logic                          out_run_end_reg, out_run_end_next;
    logic                          out_stream_end_reg, out_stream_end_next;
    logic [7:0]                    rd_data_reg;

    // History memory, newest byte just below the write pointer.
    logic [7:0]                    hist_mem [0:MAX_WINDOW-1];

    logic                          push_en;
    logic [7:0]                    push_data;
    logic                          rd_en;
    logic [DW-1:0]                 rd_i;
    logic [SW-1:0]                 rd_sum;
    logic [AW-1:0]                 rd_addr;
    logic                          emit_en;
    lz77wmt_pkg::token_t           emit_tok;
    logic                          out_free;
    logic                          mid_load;
    logic [1:0]                    cnt_eff;
    logic [7:0]                    la_k;
    logic [CW-1:0]                 ws_ext, max_ext, seen_ext, w1, w2;
    logic [DW-1:0]                 w_eff;

    // Effective search window: configured value clipped by size and history.
    always_comb
    begin
        ws_ext   = CW'(ws_reg);
        max_ext  = CW'(MAX_WINDOW);
        seen_ext = CW'(seen_reg);
        w1       = (ws_ext < max_ext) ? ws_ext : max_ext;
        w2       = (w1 < seen_ext) ? w1 : seen_ext;
        w_eff    = DW'(w2);
    end

    assign la_k    = la_sel(la0_reg, la1_reg, la2_reg, k_reg);
    assign cnt_eff = (cnt_reg >= 2'(lz77wmt_pkg::MIN_MATCH)) ? 2'd2 : cnt_reg;

    // History writes and their byte source.
    always_comb
    begin
        push_en   = cmd.emit_lit_b | cmd.ext_match | cmd.push_la | cmd.emit_nomatch;
        push_data = in_byte;
        if (cmd.emit_lit_b || cmd.ext_match)
        begin
            push_data = b_reg;
        end
        else if (cmd.push_la)
        begin
            push_data = la_k;
        end
        else if (cmd.emit_nomatch)
        begin
            push_data = la0_reg;
        end
    end

    // History read address: entry i back from the newest byte, modulo the depth.
    always_comb
    begin
        rd_en   = cmd.rd_match | cmd.srch_read;
        rd_i    = cmd.rd_match ? (off_reg - DW'(1)) : (d_reg - DW'(k_reg) - DW'(1));
        rd_sum  = SW'(wp_reg) + SW'(MAX_WINDOW - 1) - SW'(rd_i);
        if (rd_sum >= SW'(MAX_WINDOW))
        begin
            rd_addr = AW'(rd_sum - SW'(MAX_WINDOW));
        end
        else
        begin
            rd_addr = AW'(rd_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            hist_mem[wp_reg] <= push_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // Token source selection.
    always_comb
    begin
        emit_en  = cmd.emit_lit_b | cmd.emit_match | cmd.emit_nomatch | cmd.emit_tail;
        emit_tok = '{kind: lz77wmt_pkg::TK_LITERAL, value: b_reg, length: 8'd0};
        if (cmd.emit_match)
        begin
            emit_tok = '{kind: lz77wmt_pkg::TK_MATCH, value: 8'(off_reg), length: len_reg};
        end
        else if (cmd.emit_nomatch)
        begin
            emit_tok.value = la0_reg;
        end
        else if (cmd.emit_tail)
        begin
            emit_tok.value = la_k;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign mid_load = emit_en && pend_valid_reg;

    // Next-state logic for all registers.
    always_comb
    begin
        ws_next             = cfg_valid ? cfg_data : ws_reg;
        b_next              = cmd.latch ? in_byte : b_reg;
        last_next           = cmd.latch ? in_last : last_reg;
        cnt_next            = cnt_reg;
        seen_next           = seen_reg;
        in_match_next       = in_match_reg;
        wp_next             = wp_reg;
        la0_next            = la0_reg;
        la1_next            = la1_reg;
        la2_next            = la2_reg;
        off_next            = off_reg;
        len_next            = len_reg;
        d_next              = d_reg;
        k_next              = k_reg;
        pend_next           = pend_reg;
        pend_valid_next     = pend_valid_reg;
        out_tok_next        = out_tok_reg;
        out_run_end_next    = out_run_end_reg;
        out_stream_end_next = out_stream_end_reg;
        out_valid_next      = out_valid_reg && !m_tready;

        // History bookkeeping.
        if (push_en)
        begin
            wp_next = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
            if (seen_reg != DW'(MAX_WINDOW))
            begin
                seen_next = seen_reg + DW'(1);
            end
        end

        // Lookahead insert and literal shift.
        if (cmd.add_la)
        begin
            case (cnt_eff)
                2'd0:    la0_next = b_reg;
                2'd1:    la1_next = b_reg;
                default: la2_next = b_reg;
            endcase
            cnt_next = cnt_eff + 2'd1;
        end
        if (cmd.emit_nomatch)
        begin
            la0_next = la1_reg;
            la1_next = la2_reg;
            cnt_next = 2'd2;
        end

        // Running match.
        if (cmd.ext_match)
        begin
            len_next = len_reg + 8'd1;
        end
        if (cmd.emit_match)
        begin
            in_match_next = 1'b0;
            off_next      = '0;
            len_next      = '0;
        end
        if (cmd.found)
        begin
            in_match_next = 1'b1;
            off_next      = d_reg;
            len_next      = 8'(lz77wmt_pkg::MIN_MATCH);
            cnt_next      = 2'd0;
        end

        // Search offset and byte counters.
        if (cmd.srch_init)
        begin
            d_next = w_eff;
        end
        if (cmd.srch_next_d)
        begin
            d_next = d_reg - DW'(1);
        end
        if (cmd.srch_next_k || cmd.push_la || cmd.emit_tail)
        begin
            k_next = k_reg + 2'd1;
        end
        if (cmd.srch_init || cmd.srch_next_d || cmd.found || cmd.k_clear)
        begin
            k_next = 2'd0;
        end

        // End of stream returns all stream state to its start.
        if (cmd.clear_stream)
        begin
            cnt_next      = 2'd0;
            seen_next     = '0;
            in_match_next = 1'b0;
            off_next      = '0;
            len_next      = '0;
            wp_next       = '0;
        end

        // Token staging: the held token moves out once a newer one arrives, or on a flush.
        if (mid_load)
        begin
            out_tok_next        = pend_reg;
            out_run_end_next    = 1'b0;
            out_stream_end_next = 1'b0;
            out_valid_next      = 1'b1;
        end
        if (cmd.flush)
        begin
            out_tok_next        = pend_reg;
            out_run_end_next    = 1'b1;
            out_stream_end_next = last_reg;
            out_valid_next      = 1'b1;
            pend_valid_next     = 1'b0;
        end
        if (emit_en)
        begin
            pend_next       = emit_tok;
            pend_valid_next = 1'b1;
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg         <= lz77wmt_pkg::WINDOW_RESET;
            cnt_reg        <= '0;
            seen_reg       <= '0;
            in_match_reg   <= 1'b0;
            wp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            off_reg        <= '0;
            len_reg        <= '0;
        end
        else
        begin
            ws_reg         <= ws_next;
            cnt_reg        <= cnt_next;
            seen_reg       <= seen_next;
            in_match_reg   <= in_match_next;
            wp_reg         <= wp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            off_reg        <= off_next;
            len_reg        <= len_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        b_reg              <= b_next;
        last_reg           <= last_next;
        la0_reg            <= la0_next;
        la1_reg            <= la1_next;
        la2_reg            <= la2_next;
        d_reg              <= d_next;
        k_reg              <= k_next;
        pend_reg           <= pend_next;
        out_tok_reg        <= out_tok_next;
        out_run_end_reg    <= out_run_end_next;
        out_stream_end_reg <= out_stream_end_next;
    end

    // Status toward the controller.
    always_comb
    begin
        st            = '0;
        st.lit_start  = !in_match_reg && (cnt_reg == 2'd0)
                        && (seen_reg < DW'(lz77wmt_pkg::MIN_MATCH));
        st.in_match   = in_match_reg;
        st.last       = last_reg;
        st.emit_ok    = !pend_valid_reg || out_free;
        st.out_free   = out_free;
        st.pend_valid = pend_valid_reg;
        st.match_eq   = (rd_data_reg == b_reg);
        st.len_cap    = (len_reg == (lz77wmt_pkg::MAX_LEN - 8'd1));
        st.add_fills  = (cnt_eff == 2'd2);
        st.d_zero     = (d_reg == '0);
        st.k_hist     = (DW'(k_reg) < d_reg);
        st.la_eq      = (la_sel(la0_reg, la1_reg, la2_reg, k_reg - d_reg[1:0]) == la_k);
        st.rd_eq      = (rd_data_reg == la_k);
        st.k_last     = (k_reg == 2'd2);
        st.tail_more  = (k_reg < cnt_reg);
    end

    // Output channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tok_reg.length, out_tok_reg.value};
    assign m_tuser  = {out_stream_end_reg, out_tok_reg.kind};
    assign m_tlast  = out_run_end_reg;

endmodule

// ----- rtl/lz77_window_match_tokenizer_unit.sv -----
// Top level of the LZ77 window match tokenizer.
// Depends on lz77wmt_pkg, lz77wmt_ctrl and lz77wmt_dpath.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  tdata: data_byte; tlast: last_byte
//   m_*      out        m_tvalid / m_tready  tdata: offset or literal, length;
//                                             tuser: token_kind, stream_end;
//                                             tlast: run_end
//   cfg_*    in         cfg_valid/cfg_ready  window_size
//
// A new byte is taken only once the last one is done. A byte that fills the
// lookahead searches back through the history, up to three bytes per offset
// tried, and a found match writes its lookahead bytes into the history.
// Reset is asynchronous, active low, and leaves the window at ten. Each
// request of output tokens waits while m_tready is low; the last token waits
// in the output register while the next byte is taken.
module lz77_window_match_tokenizer_unit
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [7:0] literal_or_offset,
                                                       // [15:8] match_length
    output logic [1:0]                      m_tuser,   // [0] token_kind, [1] stream_end
    output logic                            m_tlast,   // run_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lz77wmt_pkg::CFG_W-1:0]   cfg_data   // window_size
);

    lz77wmt_pkg::dp_cmd_t    cmd;
    lz77wmt_pkg::dp_status_t st;

    // The window register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    lz77wmt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lz77wmt_dpath
    #(
        .MAX_WINDOW (MAX_WINDOW)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
